// ----- hw/rtl/bvce_pkg.sv -----
// ----------------------------------------------------------------------------
// bvce_pkg
// Shared types, register map and constants of the banked video memory access
// unit with colour expansion.
// ----------------------------------------------------------------------------
`default_nettype none

package bvce_pkg;

	// Default video memory size in bytes (a power of two).
	localparam int BVCE_MEM_SIZE = 1048576;

	// Width of bank placement arithmetic; covers 255 << 14 and the largest memory.
	localparam int PLACE_W = 24;

	// Configuration port address width (six 32-bit registers).
	localparam int CFG_AW = 5;

	// Register indexes.
	localparam logic [2:0] REG_BANK_A     = 3'd0;
	localparam logic [2:0] REG_BANK_B     = 3'd1;
	localparam logic [2:0] REG_BANK_CTRL  = 3'd2;
	localparam logic [2:0] REG_WRITE_MODE = 3'd3;
	localparam logic [2:0] REG_FORE       = 3'd4;
	localparam logic [2:0] REG_BACK       = 3'd5;

	// Bank control bits.
	localparam int CTRL_DUAL   = 0;
	localparam int CTRL_GRAN16 = 1;
	localparam int CTRL_SCALE8 = 2;
	localparam int CTRL_SCALE16 = 3;
	localparam int CTRL_EXT    = 4;

	// Write modes that expand bits into pixels.
	localparam logic [2:0] WM_EXPAND_FG  = 3'd4;
	localparam logic [2:0] WM_EXPAND_ALL = 3'd5;

	// Function codes (bit 1 selects the linear aperture, bit 0 a write).
	localparam logic [1:0] FUNC_WIN_READ  = 2'd0;
	localparam logic [1:0] FUNC_WIN_WRITE = 2'd1;
	localparam logic [1:0] FUNC_LIN_READ  = 2'd2;
	localparam logic [1:0] FUNC_LIN_WRITE = 2'd3;

	// Window geometry and the value returned by a missed read.
	localparam logic [PLACE_W-1:0] BANK_SPAN = PLACE_W'(32'h8000);
	localparam logic [7:0] MISS_DATA = 8'hff;

	// One input word.
	typedef struct packed {
		logic [1:0]  func;
		logic [31:0] offset;
		logic [7:0]  write_data;
	} cmd_t;

	// One result word.
	typedef struct packed {
		logic [7:0] read_data;
		logic       hit;
	} rsp_t;

	// Configuration register file contents.
	typedef struct packed {
		logic [7:0]  bank_offset_a;
		logic [7:0]  bank_offset_b;
		logic [4:0]  bank_control;
		logic [2:0]  write_mode;
		logic [15:0] fore_colour;
		logic [15:0] back_colour;
	} cfg_t;

endpackage

`default_nettype wire

// ----- hw/rtl/banked_vram_access_color_expand_core.sv -----
// An accepted command passes through the place, address and memory states; a read adds
// a read state, and a colour-expand write an expand state that steps through eight pixels.
// No new command is taken before the result is shown; the next command is taken in the cycle
// that shows the result. Expansion takes one pixel per cycle through the single memory port.
// Reset clears the sequencer and configuration registers only; video memory contents are
// undefined until written. The receiver cannot stall: done is high for exactly one cycle.
// ----------------------------------------------------------------------------
// banked_vram_access_color_expand_core
// Window and linear access to packed-pixel video memory with bank placement,
// address scaling and bit-to-pixel colour expansion.
// ----------------------------------------------------------------------------
`default_nettype none

module banked_vram_access_color_expand_core import bvce_pkg::*; #(
	parameter int MEM_SIZE = BVCE_MEM_SIZE
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	output logic                   busy,
	input  wire cmd_t              cmd,
	output logic                   done,
	output rsp_t                   result,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [CFG_AW-1:0] paddr,
	input  wire logic [31:0]       pwdata,
	output logic [31:0]            prdata,
	output logic                   pready
);

	localparam int AW = $clog2(MEM_SIZE);
	localparam logic [PLACE_W-1:0] VRAM_SZ = PLACE_W'(MEM_SIZE);

	typedef enum logic [5:0] {
		ST_IDLE   = 6'b000001,
		ST_PLACE  = 6'b000010,
		ST_ADDR   = 6'b000100,
		ST_MEM    = 6'b001000,
		ST_READ   = 6'b010000,
		ST_EXPAND = 6'b100000
	} state_t;

	cfg_t cfg;

	state_t              state_q;
	logic [1:0]          func_q;
	logic [31:0]         off_q;
	logic [7:0]          pat_q;
	logic [PLACE_W-1:0]  base_q;
	logic [PLACE_W-1:0]  lim_q;
	logic [AW-1:0]       addr_q;
	logic                hit_q;
	logic                lane_q;
	logic [2:0]          x_q;
	logic                done_q;
	rsp_t                result_q;

	logic [7:0]          sel_off;
	logic [PLACE_W-1:0]  bsh;
	logic [PLACE_W-1:0]  lim0;
	logic [PLACE_W-1:0]  base_d;
	logic [PLACE_W-1:0]  lim_d;
	logic [PLACE_W-1:0]  in_bank;
	logic [PLACE_W-1:0]  win_sum;
	logic                hit_d;
	logic [AW-1:0]       pre;
	logic [AW-1:0]       scaled;
	logic                expand;
	logic                wide;
	logic                bit_set;
	logic [15:0]         colour;
	logic [AW-1:0]       px_addr;
	logic [AW-2:0]       mem_addr;
	logic [1:0]          mem_we;
	logic [15:0]         mem_wdata;
	logic                mem_re;
	logic [15:0]         mem_rdata;

	bvce_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.cfg     (cfg)
	);

	bvce_mem #(
		.MEM_SIZE (MEM_SIZE)
	) u_mem (
		.clk   (clk),
		.addr  (mem_addr),
		.we    (mem_we),
		.wdata (mem_wdata),
		.re    (mem_re),
		.rdata (mem_rdata)
	);

	assign pready = 1'b1;
	assign busy   = (state_q != ST_IDLE);
	assign done   = done_q;
	assign result = result_q;

	// Bank placement: base and limit of the bank that the offset falls in.
	always_comb begin
		sel_off = (cfg.bank_control[CTRL_DUAL] && off_q[15]) ?
			cfg.bank_offset_b : cfg.bank_offset_a;
		bsh = cfg.bank_control[CTRL_GRAN16] ? {2'b00, sel_off, 14'd0} :
			{4'd0, sel_off, 12'd0};
		lim0   = (bsh < VRAM_SZ) ? (VRAM_SZ - bsh) : '0;
		base_d = bsh;
		lim_d  = lim0;
		if (!cfg.bank_control[CTRL_DUAL] && off_q[15]) begin
			if (lim0 > BANK_SPAN) begin
				base_d = bsh + BANK_SPAN;
				lim_d  = lim0 - BANK_SPAN;
			end else begin
				lim_d = '0;
			end
		end
	end

	// Hit test and scaled byte address.
	always_comb begin
		in_bank = {{(PLACE_W-15){1'b0}}, off_q[14:0]};
		win_sum = in_bank + base_q;
		hit_d   = func_q[1] || ((off_q[31:16] == 16'd0) && (in_bank < lim_q));
		pre     = func_q[1] ? off_q[AW-1:0] : win_sum[AW-1:0];
		if (cfg.bank_control[CTRL_SCALE16]) begin
			scaled = pre << 4;
		end else if (cfg.bank_control[CTRL_SCALE8]) begin
			scaled = pre << 3;
		end else begin
			scaled = pre;
		end
	end

	// Expansion controls and the pixel address of the current step.
	assign expand = cfg.bank_control[CTRL_EXT] &&
		((cfg.write_mode == WM_EXPAND_FG) || (cfg.write_mode == WM_EXPAND_ALL));
	assign wide    = cfg.bank_control[CTRL_SCALE16];
	assign bit_set = pat_q[7];
	assign colour  = bit_set ? cfg.fore_colour : cfg.back_colour;

	always_comb begin
		if (wide) begin
			px_addr = addr_q + {{(AW-4){1'b0}}, x_q, 1'b0};
			px_addr[0] = 1'b0;
		end else begin
			px_addr = addr_q + {{(AW-3){1'b0}}, x_q};
		end
	end

	// Memory port drive.
	always_comb begin
		mem_addr  = addr_q[AW-1:1];
		mem_we    = 2'b00;
		mem_wdata = {pat_q, pat_q};
		mem_re    = 1'b0;
		case (state_q)
			ST_MEM: begin
				if (hit_q && !func_q[0]) begin
					mem_re = 1'b1;
				end else if (hit_q && !expand) begin
					mem_we = addr_q[0] ? 2'b10 : 2'b01;
				end
			end
			ST_EXPAND: begin
				mem_addr = px_addr[AW-1:1];
				if (bit_set || (cfg.write_mode == WM_EXPAND_ALL)) begin
					if (wide) begin
						mem_we    = 2'b11;
						mem_wdata = colour;
					end else begin
						mem_we    = px_addr[0] ? 2'b10 : 2'b01;
						mem_wdata = {colour[7:0], colour[7:0]};
					end
				end
			end
			default: ;
		endcase
	end

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done_q  <= 1'b0;
			x_q     <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						state_q <= ST_PLACE;
					end
				end
				ST_PLACE: state_q <= ST_ADDR;
				ST_ADDR:  state_q <= ST_MEM;
				ST_MEM: begin
					if (hit_q && !func_q[0]) begin
						state_q <= ST_READ;
					end else if (hit_q && expand) begin
						x_q     <= '0;
						state_q <= ST_EXPAND;
					end else begin
						done_q  <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				ST_READ: begin
					done_q  <= 1'b1;
					state_q <= ST_IDLE;
				end
				ST_EXPAND: begin
					x_q <= x_q + 3'd1;
					if (x_q == 3'd7) begin
						done_q  <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					func_q <= cmd.func;
					off_q  <= cmd.offset;
					pat_q  <= cmd.write_data;
				end
			end
			ST_PLACE: begin
				base_q <= base_d;
				lim_q  <= lim_d;
			end
			ST_ADDR: begin
				addr_q <= scaled;
				hit_q  <= hit_d;
			end
			ST_MEM: begin
				lane_q <= addr_q[0];
				if (!hit_q) begin
					result_q.read_data <= func_q[0] ? 8'd0 : MISS_DATA;
					result_q.hit       <= 1'b0;
				end else begin
					result_q.read_data <= 8'd0;
					result_q.hit       <= 1'b1;
				end
			end
			ST_READ: begin
				result_q.read_data <= lane_q ? mem_rdata[15:8] : mem_rdata[7:0];
				result_q.hit       <= 1'b1;
			end
			ST_EXPAND: begin
				pat_q <= {pat_q[6:0], 1'b0};
			end
			default: ;
		endcase
	end

endmodule

`default_nettype wire

// ----- hw/rtl/bvce_regs.sv -----
// ----------------------------------------------------------------------------
// bvce_regs
// Configuration registers behind an APB-style port. Writes complete in the
// access phase; reads return the addressed register.
// ----------------------------------------------------------------------------
`default_nettype none

module bvce_regs import bvce_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [CFG_AW-1:0] paddr,
	input  wire logic [31:0]       pwdata,
	output logic [31:0]            prdata,
	output cfg_t                   cfg
);

	cfg_t       cfg_q;
	logic       wr_en;
	logic [2:0] idx;

	assign wr_en = psel && penable && pwrite;
	assign idx   = paddr[CFG_AW-1:2];

	// Register writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (wr_en) begin
			case (idx)
				REG_BANK_A:     cfg_q.bank_offset_a <= pwdata[7:0];
				REG_BANK_B:     cfg_q.bank_offset_b <= pwdata[7:0];
				REG_BANK_CTRL:  cfg_q.bank_control  <= pwdata[4:0];
				REG_WRITE_MODE: cfg_q.write_mode    <= pwdata[2:0];
				REG_FORE:       cfg_q.fore_colour   <= pwdata[15:0];
				REG_BACK:       cfg_q.back_colour   <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	// Read mux, zero extended.
	always_comb begin
		case (idx)
			REG_BANK_A:     prdata = {24'd0, cfg_q.bank_offset_a};
			REG_BANK_B:     prdata = {24'd0, cfg_q.bank_offset_b};
			REG_BANK_CTRL:  prdata = {27'd0, cfg_q.bank_control};
			REG_WRITE_MODE: prdata = {29'd0, cfg_q.write_mode};
			REG_FORE:       prdata = {16'd0, cfg_q.fore_colour};
			REG_BACK:       prdata = {16'd0, cfg_q.back_colour};
			default:        prdata = 32'd0;
		endcase
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

// ----- hw/rtl/bvce_mem.sv -----
// ----------------------------------------------------------------------------
// bvce_mem
// Video memory as two byte lanes (even and odd bytes) sharing one word
// address. One access per cycle, per-lane write enables, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module bvce_mem import bvce_pkg::*; #(
	parameter int MEM_SIZE = BVCE_MEM_SIZE
) (
	input  wire logic                              clk,
	input  wire logic [$clog2(MEM_SIZE)-2:0]       addr,
	input  wire logic [1:0]                        we,
	input  wire logic [15:0]                       wdata,
	input  wire logic                              re,
	output logic [15:0]                            rdata
);

	localparam int WORDS = MEM_SIZE / 2;

	logic [7:0] lane_lo [WORDS];
	logic [7:0] lane_hi [WORDS];

	// Even byte lane.
	always_ff @(posedge clk) begin
		if (we[0]) begin
			lane_lo[addr] <= wdata[7:0];
		end
		if (re) begin
			rdata[7:0] <= lane_lo[addr];
		end
	end

	// Odd byte lane.
	always_ff @(posedge clk) begin
		if (we[1]) begin
			lane_hi[addr] <= wdata[15:8];
		end
		if (re) begin
			rdata[15:8] <= lane_hi[addr];
		end
	end

endmodule

`default_nettype wire

// ----- hw/rtl/bvce_checker.sv -----
// ----------------------------------------------------------------------------
// bvce_checker
// Port-level checks of the access unit, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module bvce_checker import bvce_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire logic busy,
	input wire cmd_t cmd,
	input wire logic done,
	input wire rsp_t result,
	input wire logic pready
);

	// An accepted command keeps the unit busy in the next cycle.
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted word did not raise busy");

	// A result word is shown only once the unit has finished.
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result word while busy");

	// Result strobes never come back to back.
	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe lasted more than one cycle");

	// A miss returns all ones (a read) or zero (a write); the check accepts either value.
	a_miss_data: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !result.hit) |-> ((result.read_data == 8'd0) ||
			(result.read_data == MISS_DATA)))
		else $error("missed access returned unexpected data");

	// The configuration port never inserts wait states.
	a_pready: assert property (@(posedge clk) disable iff (!arst_n)
		pready)
		else $error("pready dropped");

endmodule

bind banked_vram_access_color_expand_core bvce_checker u_bvce_checker (.*);

`default_nettype wire
